/* hw/rtl/prk_pkg.sv */
// Shared types, constants and codes for the PageRank row update block.
// No dependencies; prk_ifs, pagerank_row_update and the testbench use it by scoped names.
package prk_pkg;

  localparam int DefMaxVertices  = 1024;
  localparam int DefMaxLocalRows = 256;
  localparam int DefMaxEdges     = 4096;

  localparam int ModeW  = 3;
  localparam int SlotW  = 13;
  localparam int WordW  = 32;
  localparam int VtxW   = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;
  localparam int DampW  = 16;
  localparam int TvcW   = 11;
  localparam int LvcW   = 9;

  localparam logic [ModeW-1:0] MODE_LOAD_RANK = 3'd0;
  localparam logic [ModeW-1:0] MODE_LOAD_OOFF = 3'd1;
  localparam logic [ModeW-1:0] MODE_LOAD_EDGE = 3'd2;
  localparam logic [ModeW-1:0] MODE_LOAD_ROFF = 3'd3;
  localparam logic [ModeW-1:0] MODE_RUN       = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_DAMPING = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOTAL_N = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOCAL_N = 2'd2;

  localparam logic [DampW-1:0] DAMP_RESET = 16'd55706;
  localparam logic [TvcW-1:0]  TVC_RESET  = 11'd1024;
  localparam logic [LvcW-1:0]  LVC_RESET  = 9'd256;

  typedef logic [WordW-1:0] word_t;

endpackage

/* hw/rtl/prk_ifs.sv */
// Handshake channel interfaces: input items, result items, config writes.
// Depends on prk_pkg.
interface prk_in_if;
  logic                      valid;
  logic                      ready;
  logic [prk_pkg::ModeW-1:0] mode;
  logic [prk_pkg::SlotW-1:0] slot;
  logic [prk_pkg::WordW-1:0] word;
  modport source (output valid, mode, slot, word, input ready);
  modport sink (input valid, mode, slot, word, output ready);
endinterface

interface prk_out_if;
  logic                      valid;
  logic                      ready;
  logic [prk_pkg::VtxW-1:0]  vertex;
  logic [prk_pkg::WordW-1:0] new_rank;
  logic                      bad_slot;
  modport source (output valid, vertex, new_rank, bad_slot, input ready);
  modport sink (input valid, vertex, new_rank, bad_slot, output ready);
endinterface

interface prk_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [prk_pkg::CfgIdxW-1:0] index;
  logic [prk_pkg::CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/prk_div.sv */
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
// Standalone; used by pagerank_row_update for reciprocals and teleport.
module prk_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [32:0] quot
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [32:0] dvd_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [32:0] trial;
  logic        take;

  assign trial = {rem_r, dvd_r[32]};
  assign take  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd33;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
      dvd_r <= {dvd_r[31:0], take};
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

/* hw/rtl/prk_mul.sv */
// Shared 32x32 multiplier with registered product.
// Standalone; used by pagerank_row_update for edge terms and damping.
module prk_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * 64'(b);
    end
  end

  assign prod = prod_r;

endmodule

/* hw/rtl/pagerank_row_update.sv */
// Top level: PageRank row update with four memories and a sequencer.
// Depends on prk_pkg, prk_ifs, prk_div and prk_mul.
//
// Load items (modes 0 to 3) write one memory word when the slot is in range. A run
// item (mode 4) first divides for the teleport term, then reads the row offsets
// and walks the in-edges; an edge whose source has degree zero or one needs no
// division, while any other edge forms a reciprocal in the one-bit-per-cycle
// divider. A run index out of range answers with bad_slot set. The block takes
// no item while a run is in progress; its result waits in an output register.
module pagerank_row_update #(
  parameter int MAX_VERTICES   = prk_pkg::DefMaxVertices,
  parameter int MAX_LOCAL_ROWS = prk_pkg::DefMaxLocalRows,
  parameter int MAX_EDGES      = prk_pkg::DefMaxEdges
) (
  input logic       clk,
  input logic       rst_n,
  prk_in_if.sink    in_ch,
  prk_out_if.source out_ch,
  prk_cfg_if.sink   cfg_ch
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int OAW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EIW = $clog2(MAX_EDGES + 1);
  localparam int RAW = $clog2(MAX_LOCAL_ROWS + 1);
  localparam int SW  = 32 + EIW;
  localparam int HW  = SW - 32;
  localparam int TvcW_N = prk_pkg::TvcW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TELE  = 4'd1;
  localparam logic [3:0] S_ROW0  = 4'd2;
  localparam logic [3:0] S_ROW1  = 4'd3;
  localparam logic [3:0] S_ROW2  = 4'd4;
  localparam logic [3:0] S_EDGE  = 4'd5;
  localparam logic [3:0] S_SRC   = 4'd6;
  localparam logic [3:0] S_OFF1  = 4'd7;
  localparam logic [3:0] S_OFF2  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_TERM  = 4'd10;
  localparam logic [3:0] S_SCLO  = 4'd11;
  localparam logic [3:0] S_SCHI  = 4'd12;
  localparam logic [3:0] S_SCFIN = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_r, state_nxt;

  logic [prk_pkg::DampW-1:0] damp_r;
  logic [prk_pkg::TvcW-1:0]  tvc_r;
  logic [prk_pkg::LvcW-1:0]  lvc_r;

  prk_pkg::word_t rank_mem [MAX_VERTICES];
  prk_pkg::word_t ooff_mem [MAX_VERTICES + 1];
  prk_pkg::word_t edge_mem [MAX_EDGES];
  prk_pkg::word_t roff_mem [MAX_LOCAL_ROWS + 1];

  prk_pkg::word_t rank_rd_r, ooff_rd_r, edge_rd_r, roff_rd_r;
  logic [VAW-1:0] rank_addr;
  logic [OAW-1:0] ooff_addr;
  logic [EAW-1:0] edge_addr;
  logic [RAW-1:0] roff_addr;

  logic [prk_pkg::SlotW-1:0] slot_r;
  logic [31:0]    tele_r;
  logic [31:0]    start_r;
  logic [EIW-1:0] ci_r, ci_nxt;
  logic [EIW-1:0] stop_r, stop_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [OAW-1:0] src_r;
  logic [31:0]    lo_r;
  logic [31:0]    rnk_r;
  logic [47:0]    lo_prod_r;
  logic [31:0]    res_r, res_nxt;
  logic           bad_r, bad_nxt;

  logic                       out_valid_r;
  logic [prk_pkg::VtxW-1:0]   out_vertex_r;
  logic [31:0]                out_rank_r;
  logic                       out_bad_r;

  logic        in_acc;
  logic        run_bad;
  logic        div_start;
  logic [32:0] div_dvd;
  logic [31:0] div_dsr;
  logic        div_done;
  logic [32:0] div_quot;
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;

  logic [31:0]      stop_c;
  logic [31:0]      deg;
  logic [SW+15:0]   scaled_full;
  logic [SW:0]      total;
  logic [TvcW_N-1:0] n_eff;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign run_bad = (32'(in_ch.slot) >= 32'(lvc_r)) ||
                   (32'(in_ch.slot) >= 32'(MAX_LOCAL_ROWS));
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign n_eff  = (tvc_r == '0) ? TvcW_N'(1) : tvc_r;
  assign stop_c = (roff_rd_r > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : roff_rd_r;
  assign deg    = ooff_rd_r - lo_r;
  assign scaled_full = (SW + 16)'({mul_prod[HW+15:0], 32'd0}) + (SW + 16)'(lo_prod_r);
  assign total  = (SW + 1)'(scaled_full[SW+15:16]) + (SW + 1)'(tele_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r <= prk_pkg::DAMP_RESET;
      tvc_r  <= prk_pkg::TVC_RESET;
      lvc_r  <= prk_pkg::LVC_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        prk_pkg::REG_DAMPING: damp_r <= cfg_ch.data;
        prk_pkg::REG_TOTAL_N: tvc_r  <= cfg_ch.data[prk_pkg::TvcW-1:0];
        prk_pkg::REG_LOCAL_N: lvc_r  <= cfg_ch.data[prk_pkg::LvcW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.mode == prk_pkg::MODE_LOAD_RANK &&
        32'(in_ch.slot) < 32'(MAX_VERTICES)) begin
      rank_mem[VAW'(32'(in_ch.slot))] <= in_ch.word;
    end
    if (in_acc && in_ch.mode == prk_pkg::MODE_LOAD_OOFF &&
        32'(in_ch.slot) <= 32'(MAX_VERTICES)) begin
      ooff_mem[OAW'(32'(in_ch.slot))] <= in_ch.word;
    end
    if (in_acc && in_ch.mode == prk_pkg::MODE_LOAD_EDGE &&
        32'(in_ch.slot) < 32'(MAX_EDGES)) begin
      edge_mem[EAW'(32'(in_ch.slot))] <= in_ch.word;
    end
    if (in_acc && in_ch.mode == prk_pkg::MODE_LOAD_ROFF &&
        32'(in_ch.slot) <= 32'(MAX_LOCAL_ROWS)) begin
      roff_mem[RAW'(32'(in_ch.slot))] <= in_ch.word;
    end
    rank_rd_r <= rank_mem[rank_addr];
    ooff_rd_r <= ooff_mem[ooff_addr];
    edge_rd_r <= edge_mem[edge_addr];
    roff_rd_r <= roff_mem[roff_addr];
  end

  always_comb begin
    state_nxt = state_r;
    ci_nxt    = ci_r;
    stop_nxt  = stop_r;
    sum_nxt   = sum_r;
    res_nxt   = res_r;
    bad_nxt   = bad_r;
    rank_addr = src_r[VAW-1:0];
    ooff_addr = src_r;
    edge_addr = ci_r[EAW-1:0];
    roff_addr = RAW'(32'(slot_r));
    div_start = 1'b0;
    div_dvd   = 33'h1_0000_0000;
    div_dsr   = deg;
    mul_en    = 1'b0;
    mul_a     = rnk_r;
    mul_b     = div_quot[31:0];
    case (state_r)
      S_IDLE: begin
        div_dvd = 33'({(17)'(18'h10000 - 18'(damp_r)), 14'd0});
        div_dsr = 32'(n_eff);
        sum_nxt = '0;
        if (in_acc && in_ch.mode == prk_pkg::MODE_RUN) begin
          if (run_bad) begin
            res_nxt   = '0;
            bad_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            bad_nxt   = 1'b0;
            div_start = 1'b1;
            state_nxt = S_TELE;
          end
        end
      end
      S_TELE: begin
        if (div_done) begin
          state_nxt = S_ROW0;
        end
      end
      S_ROW0: begin
        state_nxt = S_ROW1;
      end
      S_ROW1: begin
        roff_addr = RAW'(32'(slot_r) + 32'd1);
        state_nxt = S_ROW2;
      end
      S_ROW2: begin
        if (start_r < stop_c) begin
          ci_nxt    = EIW'(start_r);
          stop_nxt  = EIW'(stop_c);
          state_nxt = S_EDGE;
        end else begin
          state_nxt = S_SCLO;
        end
      end
      S_EDGE: begin
        state_nxt = (ci_r < stop_r) ? S_SRC : S_SCLO;
      end
      S_SRC: begin
        ci_nxt = ci_r + EIW'(1);
        if (edge_rd_r >= 32'(MAX_VERTICES)) begin
          state_nxt = S_EDGE;
        end else begin
          rank_addr = VAW'(edge_rd_r);
          ooff_addr = OAW'(edge_rd_r);
          state_nxt = S_OFF1;
        end
      end
      S_OFF1: begin
        ooff_addr = OAW'(32'(src_r) + 32'd1);
        state_nxt = S_OFF2;
      end
      S_OFF2: begin
        if (ooff_rd_r <= lo_r) begin
          state_nxt = S_EDGE;
        end else if (deg == 32'd1) begin
          sum_nxt   = sum_r + SW'(rnk_r);
          state_nxt = S_EDGE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mul_en    = 1'b1;
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        sum_nxt   = sum_r + SW'(mul_prod[63:32]);
        state_nxt = S_EDGE;
      end
      S_SCLO: begin
        mul_en    = 1'b1;
        mul_a     = sum_r[31:0];
        mul_b     = 32'(damp_r);
        state_nxt = S_SCHI;
      end
      S_SCHI: begin
        mul_en    = 1'b1;
        mul_a     = 32'(sum_r[SW-1:32]);
        mul_b     = 32'(damp_r);
        state_nxt = S_SCFIN;
      end
      S_SCFIN: begin
        res_nxt   = (total > (SW + 1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : total[31:0];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ci_r   <= ci_nxt;
    stop_r <= stop_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
    bad_r  <= bad_nxt;
    if (state_r == S_IDLE && in_acc) begin
      slot_r <= in_ch.slot;
    end
    if (state_r == S_TELE && div_done) begin
      tele_r <= div_quot[31:0];
    end
    if (state_r == S_ROW1) begin
      start_r <= roff_rd_r;
    end
    if (state_r == S_SRC) begin
      src_r <= OAW'(edge_rd_r);
    end
    if (state_r == S_OFF1) begin
      lo_r  <= ooff_rd_r;
      rnk_r <= rank_rd_r;
    end
    if (state_r == S_SCHI) begin
      lo_prod_r <= mul_prod[47:0];
    end
    if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_vertex_r <= slot_r[prk_pkg::VtxW-1:0];
      out_rank_r   <= res_r;
      out_bad_r    <= bad_r;
    end
  end

  prk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot)
  );

  prk_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.vertex   = out_vertex_r;
  assign out_ch.new_rank = out_rank_r;
  assign out_ch.bad_slot = out_bad_r;

endmodule

/* tb/tb_pagerank_row_update.sv */
// Self-checking testbench for pagerank_row_update: loads graph memories,
// runs rows and checks each new rank against a built-in fixed-point predictor.
// Depends on prk_pkg, prk_ifs and the RTL of the block.
`timescale 1ns / 100ps

module tb_pagerank_row_update;

  localparam logic [prk_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam logic [prk_pkg::ModeW-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [prk_pkg::ModeW-1:0] MODE_SPARE_HI = 3'd7;
  localparam int NV = prk_pkg::DefMaxVertices;
  localparam int NR = prk_pkg::DefMaxLocalRows;
  localparam int NE = prk_pkg::DefMaxEdges;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [prk_pkg::VtxW-1:0] vertex;
    prk_pkg::word_t           new_rank;
    logic                     bad_slot;
  } rank_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  prk_in_if  in_ch ();
  prk_out_if out_ch ();
  prk_cfg_if cfg_ch ();

  pagerank_row_update dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  prk_pkg::word_t rank_mem [NV];
  prk_pkg::word_t oof_mem [NV+1];
  prk_pkg::word_t src_mem [NE];
  prk_pkg::word_t roff_mem [NR+1];
  bit rank_set [NV];
  bit oof_set [NV+1];
  bit src_set [NE];
  bit roff_set [NR+1];
  logic [prk_pkg::DampW-1:0] alpha_q16;
  logic [prk_pkg::TvcW-1:0] graph_n;
  logic [prk_pkg::LvcW-1:0] rows_served;

  rank_item_t pending_ranks [$];
  int errors = 0;
  int sent_items = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99, 0) < 26);
  endfunction

  function automatic logic [63:0] edge_share(prk_pkg::word_t src);
    prk_pkg::word_t lo, hi, deg;
    if (src >= NV) return 64'd0;
    lo = oof_mem[src];
    hi = oof_mem[src+1];
    if (hi <= lo) return 64'd0;
    deg = hi - lo;
    if (deg == 1) return {32'd0, rank_mem[src]};
    return ({32'd0, rank_mem[src]} * (64'h1_0000_0000 / {32'd0, deg})) >> 32;
  endfunction

  function automatic prk_pkg::word_t row_rank(int v);
    logic [63:0] sum, scaled, tele, n, total;
    prk_pkg::word_t start, stop;
    sum = 0;
    start = roff_mem[v];
    stop = roff_mem[v+1];
    if (stop > NE) stop = NE;
    for (longint ci = start; ci < stop; ci++) sum += edge_share(src_mem[ci]);
    scaled = (sum * alpha_q16) >> 16;
    n = (graph_n == 0) ? 64'd1 : {53'd0, graph_n};
    tele = ((64'd65536 - alpha_q16) << 14) / n;
    total = scaled + tele;
    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
    return total[31:0];
  endfunction

  // true when a run of this row touches only written memory
  function automatic bit row_loaded(int v);
    prk_pkg::word_t start, stop, src;
    if (v >= NR || v >= rows_served) return 1'b1;
    if (!roff_set[v] || !roff_set[v+1]) return 1'b0;
    start = roff_mem[v];
    stop = roff_mem[v+1];
    if (stop > NE) stop = NE;
    for (longint ci = start; ci < stop; ci++) begin
      if (!src_set[ci]) return 1'b0;
      src = src_mem[ci];
      if (src < NV) begin
        if (!oof_set[src] || !oof_set[src+1]) return 1'b0;
        if (oof_mem[src+1] > oof_mem[src] && !rank_set[src]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic apply_item(logic [prk_pkg::ModeW-1:0] mode,
                            logic [prk_pkg::SlotW-1:0] slot, prk_pkg::word_t word);
    rank_item_t r;
    case (mode)
      prk_pkg::MODE_LOAD_RANK:
        if (slot < NV) begin rank_mem[slot] = word; rank_set[slot] = 1; end
      prk_pkg::MODE_LOAD_OOFF:
        if (slot <= NV) begin oof_mem[slot] = word; oof_set[slot] = 1; end
      prk_pkg::MODE_LOAD_EDGE:
        if (slot < NE) begin src_mem[slot] = word; src_set[slot] = 1; end
      prk_pkg::MODE_LOAD_ROFF:
        if (slot <= NR) begin roff_mem[slot] = word; roff_set[slot] = 1; end
      prk_pkg::MODE_RUN: begin
        r.vertex = slot[prk_pkg::VtxW-1:0];
        if (slot >= rows_served || slot >= NR) begin
          r.new_rank = '0;
          r.bad_slot = 1'b1;
        end else begin
          r.new_rank = row_rank(slot);
          r.bad_slot = 1'b0;
        end
        pending_ranks.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [prk_pkg::ModeW-1:0] mode,
                           logic [prk_pkg::SlotW-1:0] slot, prk_pkg::word_t word);
    @(negedge clk);
    while (roll_idle()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.slot = slot;
    in_ch.word = word;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(mode, slot, word);
    sent_items++;
  endtask

  task automatic send_noise();
    int pick;
    pick = $urandom_range(4, 0);
    case (pick)
      0: send_item(prk_pkg::MODE_LOAD_RANK, $urandom_range(8191, NV), $urandom);
      1: send_item(prk_pkg::MODE_LOAD_OOFF, $urandom_range(8191, NV + 1), $urandom);
      2: send_item(prk_pkg::MODE_LOAD_EDGE, $urandom_range(8191, NE), $urandom);
      3: send_item(prk_pkg::MODE_LOAD_ROFF, $urandom_range(8191, NR + 1), $urandom);
      default: send_item($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO), $urandom, $urandom);
    endcase
    sent_items--;
  endtask

  task automatic send_run(int v);
    if (row_loaded(v)) send_item(prk_pkg::MODE_RUN, v, $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [prk_pkg::CfgIdxW-1:0] idx,
                           logic [prk_pkg::CfgDatW-1:0] data);
    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      prk_pkg::REG_DAMPING: alpha_q16 = data;
      prk_pkg::REG_TOTAL_N: graph_n = data[prk_pkg::TvcW-1:0];
      prk_pkg::REG_LOCAL_N: rows_served = data[prk_pkg::LvcW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_directed();
    send_item(prk_pkg::MODE_LOAD_RANK, 0, 32'hFFFF_FFFF);
    send_item(prk_pkg::MODE_LOAD_RANK, 1, 32'h4000_0000);
    send_item(prk_pkg::MODE_LOAD_RANK, 2, 32'h1234_5678);
    send_item(prk_pkg::MODE_LOAD_OOFF, 0, 0);
    send_item(prk_pkg::MODE_LOAD_OOFF, 1, 1);
    send_item(prk_pkg::MODE_LOAD_OOFF, 2, 1);
    send_item(prk_pkg::MODE_LOAD_OOFF, 3, 4);
    send_item(prk_pkg::MODE_LOAD_EDGE, 0, 0);
    send_item(prk_pkg::MODE_LOAD_EDGE, 1, 1);
    send_item(prk_pkg::MODE_LOAD_EDGE, 2, 2);
    send_item(prk_pkg::MODE_LOAD_EDGE, 3, 32'hFFFF_FFFF);
    send_item(prk_pkg::MODE_LOAD_EDGE, NE - 1, 2);
    send_item(prk_pkg::MODE_LOAD_ROFF, 0, 0);
    send_item(prk_pkg::MODE_LOAD_ROFF, 1, 4);
    send_item(prk_pkg::MODE_LOAD_ROFF, 2, 2);
    send_item(prk_pkg::MODE_LOAD_ROFF, 4, NE - 1);
    send_item(prk_pkg::MODE_LOAD_ROFF, 5, 32'hFFFF_FFFF);
    send_item(prk_pkg::MODE_LOAD_ROFF, NR - 1, 0);
    send_item(prk_pkg::MODE_LOAD_ROFF, NR, 4);
    send_run(0);
    send_run(1);
    send_run(4);
    send_run(NR - 1);
    send_item(prk_pkg::MODE_RUN, NR, 0);
    send_item(prk_pkg::MODE_RUN, 8191, 32'hFFFF_FFFF);
    send_noise();
    send_noise();
  endtask

  task automatic test_config_extremes();
    cfg_write(prk_pkg::REG_DAMPING, 16'hFFFF);
    cfg_write(prk_pkg::REG_TOTAL_N, 16'd0);
    send_run(0);
    send_run(4);
    cfg_write(prk_pkg::REG_DAMPING, 16'd0);
    cfg_write(prk_pkg::REG_TOTAL_N, 16'd1);
    cfg_write(prk_pkg::REG_LOCAL_N, 16'd1);
    send_run(0);
    send_run(1);
    cfg_write(prk_pkg::REG_LOCAL_N, 16'd0);
    send_run(0);
    cfg_write(prk_pkg::REG_TOTAL_N, 16'd2047);
    cfg_write(prk_pkg::REG_LOCAL_N, 16'd511);
    cfg_write(REG_SPARE, 16'hFFFF);
    send_run(0);
    send_run(NR - 1);
    send_item(prk_pkg::MODE_RUN, NR + 3, 0);
  endtask

  task automatic pick_config();
    int p;
    p = $urandom_range(3, 0);
    cfg_write(prk_pkg::REG_DAMPING, p == 0 ? 16'd0 : p == 1 ? 16'hFFFF :
              p == 2 ? prk_pkg::DAMP_RESET : $urandom);
    p = $urandom_range(4, 0);
    cfg_write(prk_pkg::REG_TOTAL_N, p == 0 ? 16'd0 : p == 1 ? 16'd1 : p == 2 ? 16'd2047 :
              p == 3 ? 16'd1024 : $urandom_range(2047, 1));
    p = $urandom_range(9, 0);
    cfg_write(prk_pkg::REG_LOCAL_N, p < 6 ? 16'd256 : p == 6 ? 16'd511 :
              $urandom_range(511, 0));
  endtask

  task automatic load_graph(output int row_base, output int row_count, input bit hold_once);
    int nv, eb, deg, nxt;
    prk_pkg::word_t ooff;
    nv = $urandom_range(30, 2);
    eb = $urandom_range(NE - 120, 0);
    row_count = $urandom_range(16, 1);
    row_base = $urandom_range(NR - row_count, 0);
    for (int i = 0; i < nv; i++) begin
      send_item(prk_pkg::MODE_LOAD_RANK, i,
                $urandom_range(3, 0) == 0 ? 32'hFFFF_FFF0 | $urandom : $urandom);
      if ($urandom_range(99, 0) < 8) send_noise();
    end
    ooff = $urandom_range(3, 0) == 0 ? $urandom : $urandom_range(100, 0);
    for (int i = 0; i <= nv; i++) begin
      send_item(prk_pkg::MODE_LOAD_OOFF, i, ooff);
      deg = $urandom_range(9, 0);
      if (deg >= 7) ooff = ooff + $urandom_range(70000, 4);
      else if (deg == 6) ooff = $urandom;
      else ooff = ooff + deg / 2;
    end
    nxt = eb;
    for (int r = 0; r <= row_count; r++) begin
      if (r == row_count / 2 && hold_once) drain();
      if (r > 0) begin
        deg = $urandom_range(6, 0);
        for (int e = 0; e < deg; e++) begin
          send_item(prk_pkg::MODE_LOAD_EDGE, nxt, $urandom_range(9, 0) == 0 ? $urandom :
                    $urandom_range(nv - 1, 0));
          nxt++;
        end
      end
      if ($urandom_range(19, 0) == 0) send_item(prk_pkg::MODE_LOAD_ROFF, row_base + r, nxt + 3);
      else send_item(prk_pkg::MODE_LOAD_ROFF, row_base + r, nxt);
    end
  endtask

  task automatic test_random_graphs();
    int rb, rc, phase;
    phase = 0;
    while (sent_items < 750) begin
      calm = (phase == 1);
      pick_config();
      load_graph(rb, rc, phase == 2);
      repeat (2 * rc + 4) begin
        if ($urandom_range(9, 0) == 0) send_run($urandom_range(8191, 0));
        else send_run(rb + $urandom_range(rc - 1, 0));
        if ($urandom_range(99, 0) < 5) send_noise();
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99, 0) >= 26);
  end

  always @(posedge clk) begin
    rank_item_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_ranks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result vertex %0d rank %h bad %b",
                                   out_ch.vertex, out_ch.new_rank, out_ch.bad_slot);
      end else begin
        want = pending_ranks.pop_front();
        if (out_ch.vertex !== want.vertex || out_ch.new_rank !== want.new_rank ||
            out_ch.bad_slot !== want.bad_slot) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected vertex %0d rank %h bad %b, got %0d %h %b",
                     want.vertex, want.new_rank, want.bad_slot,
                     out_ch.vertex, out_ch.new_rank, out_ch.bad_slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_pagerank_row_update NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.slot = '0;
    in_ch.word = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    alpha_q16 = prk_pkg::DAMP_RESET;
    graph_n = prk_pkg::TVC_RESET;
    rows_served = prk_pkg::LVC_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_extremes();
    test_random_graphs();
    @(negedge clk);
    in_ch.valid = 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_ranks.size() == 0) begin
      $display("tb_pagerank_row_update OK");
    end else begin
      $display("tb_pagerank_row_update NOT OK");
    end
    $finish;
  end

endmodule

/* pagerank_row_update.f */
hw/rtl/prk_pkg.sv
hw/rtl/prk_ifs.sv
hw/rtl/prk_div.sv
hw/rtl/prk_mul.sv
hw/rtl/pagerank_row_update.sv
tb/tb_pagerank_row_update.sv
